// ===== rtl/grid_pattern_lock_macros.svh =====
// ---------------------------------------------------------------------------
// grid_pattern_lock assertion macros
// Concurrent assertion wrappers. Bodies are empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef GRID_PATTERN_LOCK_MACROS_SVH
`define GRID_PATTERN_LOCK_MACROS_SVH
`ifndef SYNTH
// check prop at every clock edge outside of reset
`define GPL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check that cond at one edge implies prop at the next edge
`define GPL_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define GPL_ASSERT(label, clk, rst, prop, msg)
`define GPL_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

// ===== rtl/gpl_pkg.sv =====
// ---------------------------------------------------------------------------
// gpl_pkg
// Shared constants, operation and cause codes and types of grid_pattern_lock.
// ---------------------------------------------------------------------------
`default_nettype none

package gpl_pkg;

   localparam int KEY_COUNT_DEFAULT   = 9;
   localparam int SIDE_PIXELS_DEFAULT = 768;

   localparam int OP_W     = 3;
   localparam int CAUSE_W  = 2;
   localparam int CELL_W   = 4;
   localparam int PIXEL_W  = 10;
   localparam int GRID_CELLS = 9;

   // operation codes of a request
   localparam logic [OP_W-1:0] OP_PRIMARY_CLICK = 3'd0;
   localparam logic [OP_W-1:0] OP_OTHER_CLICK   = 3'd1;
   localparam logic [OP_W-1:0] OP_ESCAPE_KEY    = 3'd2;
   localparam logic [OP_W-1:0] OP_OTHER_KEY     = 3'd3;
   localparam logic [OP_W-1:0] OP_CLOSE         = 3'd4;

   // finish causes
   localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_QUIT  = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_MATCH = 2'd2;

   // ring entry that holds no cell
   localparam logic [CELL_W-1:0] EMPTY_CELL = 4'hF;

   // configuration register indexes
   localparam logic REG_COMBINATION_CODE = 1'b0;

   typedef struct packed {
      logic advance;   // a live event is being processed this cycle
      logic write;     // the event appends a cell to the ring
   } ring_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/gpl_cell_map.sv =====
// ---------------------------------------------------------------------------
// gpl_cell_map
// Maps a pointer position to a 3x3 grid cell, column plus three times row.
// ---------------------------------------------------------------------------
`default_nettype none

module gpl_cell_map #(
   parameter int SIDE_PIXELS = gpl_pkg::SIDE_PIXELS_DEFAULT
) (
   input  wire logic [gpl_pkg::PIXEL_W-1:0] pointer_x,
   input  wire logic [gpl_pkg::PIXEL_W-1:0] pointer_y,
   output logic      [gpl_pkg::CELL_W-1:0]  cell_index
);

   localparam int CMP_W   = 13;
   localparam int CELL_PX = SIDE_PIXELS / 3;

   localparam logic [CMP_W-1:0] EDGE_ONE = CMP_W'(CELL_PX);
   localparam logic [CMP_W-1:0] EDGE_TWO = CMP_W'(2 * CELL_PX);

   logic [CMP_W-1:0] x_ext;
   logic [CMP_W-1:0] y_ext;
   logic [1:0]       col;
   logic [1:0]       row;

   assign x_ext = CMP_W'(pointer_x);
   assign y_ext = CMP_W'(pointer_y);

   // saturate at the last column and row
   always_comb begin
      if (x_ext >= EDGE_TWO) begin
         col = 2'd2;
      end else if (x_ext >= EDGE_ONE) begin
         col = 2'd1;
      end else begin
         col = 2'd0;
      end
      if (y_ext >= EDGE_TWO) begin
         row = 2'd2;
      end else if (y_ext >= EDGE_ONE) begin
         row = 2'd1;
      end else begin
         row = 2'd0;
      end
   end

   assign cell_index = {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};

endmodule

`default_nettype wire

// ===== rtl/gpl_key_ring.sv =====
// ---------------------------------------------------------------------------
// gpl_key_ring
// Shift line of the last KEY_COUNT cells, oldest at entry 0, with a
// parallel compare against the combination code.
// ---------------------------------------------------------------------------
`default_nettype none

module gpl_key_ring #(
   parameter int KEY_COUNT = gpl_pkg::KEY_COUNT_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire gpl_pkg::ring_ctrl_type                ctrl,
   input  wire logic [gpl_pkg::CELL_W-1:0]            new_cell,
   input  wire logic [gpl_pkg::CELL_W*KEY_COUNT-1:0]  code,
   output logic                                       match
);

   logic [gpl_pkg::CELL_W-1:0] ring_ff [KEY_COUNT];
   logic [gpl_pkg::CELL_W-1:0] ring_in [KEY_COUNT];
   logic [KEY_COUNT-1:0]       entry_eq;

   // ring contents after this event's write
   always_comb begin
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (ctrl.write) begin
            ring_in[i] = (i == KEY_COUNT - 1) ? new_cell : ring_ff[(i + 1) % KEY_COUNT];
         end else begin
            ring_in[i] = ring_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < KEY_COUNT; i++) begin
         entry_eq[i] = (ring_in[i] == code[i*gpl_pkg::CELL_W +: gpl_pkg::CELL_W]);
      end
   end

   assign match = &entry_eq;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_COUNT; i++) begin
            ring_ff[i] <= gpl_pkg::EMPTY_CELL;
         end
      end else if (ctrl.advance) begin
         // empty the ring on a match
         for (int i = 0; i < KEY_COUNT; i++) begin
            ring_ff[i] <= match ? gpl_pkg::EMPTY_CELL : ring_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/grid_pattern_lock.sv =====
// ---------------------------------------------------------------------------
// grid_pattern_lock
// Pattern combination lock: primary clicks on a 3x3 grid feed a ring that
// is compared with a configured code after every event.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  operation, pointer_x, pointer_y
// rsp_      out        rsp_valid/rsp_ready  locked, finished, finish_cause,
//                                           cell_recorded, cell_index
// csr_      in         APB, pready high     combination_code at address 0
//
// One request per cycle while responses are taken. An accepted request is
// held in the input register; its response is valid once it has moved into
// the result register.
// Grid mapping, ring write and the KEY_COUNT nibble compares are
// combinational between the two registers.
// Reset is synchronous and clears state, ring, code and both valid flags.
// A stalled response holds the result register; the input register then
// holds its request and req_ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

`include "grid_pattern_lock_macros.svh"

module grid_pattern_lock #(
   parameter int KEY_COUNT   = gpl_pkg::KEY_COUNT_DEFAULT,
   parameter int SIDE_PIXELS = gpl_pkg::SIDE_PIXELS_DEFAULT,
   localparam int CODE_W     = gpl_pkg::CELL_W * KEY_COUNT,
   localparam int CSR_DATA_W = (CODE_W > 32) ? 64 : 32,
   localparam int CSR_ADDR_W = (CSR_DATA_W == 64) ? 4 : 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [gpl_pkg::OP_W-1:0]      req_operation,
   input  wire logic [gpl_pkg::PIXEL_W-1:0]   req_pointer_x,
   input  wire logic [gpl_pkg::PIXEL_W-1:0]   req_pointer_y,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_locked,
   output logic                               rsp_finished,
   output logic [gpl_pkg::CAUSE_W-1:0]        rsp_finish_cause,
   output logic                               rsp_cell_recorded,
   output logic [gpl_pkg::CELL_W-1:0]         rsp_cell_index,

   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [CSR_ADDR_W-1:0]         paddr,
   input  wire logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]              prdata,
   output logic                               pready
);

   // configuration
   logic              code_sel;
   logic [CODE_W-1:0] code_ff;

   assign code_sel = (paddr[CSR_ADDR_W-1] == gpl_pkg::REG_COMBINATION_CODE);
   assign pready   = 1'b1;
   assign prdata   = code_sel ? CSR_DATA_W'(code_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '0;
      end else if (psel && penable && pwrite && pready && code_sel) begin
         code_ff <= pwdata[CODE_W-1:0];
      end
   end

   // input register
   logic                          in_valid_ff;
   logic [gpl_pkg::OP_W-1:0]      in_op_ff;
   logic [gpl_pkg::PIXEL_W-1:0]   in_x_ff;
   logic [gpl_pkg::PIXEL_W-1:0]   in_y_ff;
   logic                          out_free;
   logic                          in_advance;

   assign out_free   = !rsp_valid || rsp_ready;
   assign in_advance = in_valid_ff && out_free;
   assign req_ready  = !in_valid_ff || in_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff <= req_operation;
         in_x_ff  <= req_pointer_x;
         in_y_ff  <= req_pointer_y;
      end
   end

   // event decode
   logic                          armed_ff;
   logic                          done_ff;
   logic                          armed_in;
   logic                          done_in;
   logic                          live;
   logic                          is_primary;
   logic                          arm_now;
   logic                          quit;
   logic                          matched;
   logic                          ring_match;
   logic [gpl_pkg::CELL_W-1:0]    grid_cell;
   gpl_pkg::ring_ctrl_type        ring_ctrl;
   logic [gpl_pkg::CAUSE_W-1:0]   cause;

   assign live       = in_advance && !done_ff;
   assign is_primary = (in_op_ff == gpl_pkg::OP_PRIMARY_CLICK);
   assign arm_now    = live && is_primary && !armed_ff;
   assign quit       = live && ((in_op_ff == gpl_pkg::OP_CLOSE) ||
                                ((in_op_ff == gpl_pkg::OP_ESCAPE_KEY) && !armed_ff));

   assign ring_ctrl.advance = live;
   assign ring_ctrl.write   = live && is_primary && armed_ff;

   gpl_cell_map #(
      .SIDE_PIXELS (SIDE_PIXELS)
   ) u_cell_map (
      .pointer_x  (in_x_ff),
      .pointer_y  (in_y_ff),
      .cell_index (grid_cell)
   );

   gpl_key_ring #(
      .KEY_COUNT (KEY_COUNT)
   ) u_key_ring (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ring_ctrl),
      .new_cell (grid_cell),
      .code     (code_ff),
      .match    (ring_match)
   );

   assign matched  = live && ring_match;
   // a match disarms and wins over a quit on the same event
   assign armed_in = matched ? 1'b0 : (armed_ff || arm_now);
   assign done_in  = done_ff || quit || matched;

   always_comb begin
      if (matched) begin
         cause = gpl_pkg::CAUSE_MATCH;
      end else if (quit) begin
         cause = gpl_pkg::CAUSE_QUIT;
      end else begin
         cause = gpl_pkg::CAUSE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else if (in_advance) begin
         armed_ff <= armed_in;
         done_ff  <= done_in;
      end
   end

   // result register
   logic                        rsp_valid_ff;
   logic                        rsp_locked_ff;
   logic                        rsp_finished_ff;
   logic [gpl_pkg::CAUSE_W-1:0] rsp_cause_ff;
   logic                        rsp_recorded_ff;
   logic [gpl_pkg::CELL_W-1:0]  rsp_cell_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         rsp_locked_ff   <= armed_in;
         rsp_finished_ff <= done_in;
         rsp_cause_ff    <= cause;
         rsp_recorded_ff <= ring_ctrl.write;
         rsp_cell_ff     <= ring_ctrl.write ? grid_cell : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_locked        = rsp_locked_ff;
   assign rsp_finished      = rsp_finished_ff;
   assign rsp_finish_cause  = rsp_cause_ff;
   assign rsp_cell_recorded = rsp_recorded_ff;
   assign rsp_cell_index    = rsp_cell_ff;

   // assertions
   `GPL_ASSERT_NEXT(a_done_sticky, clock, reset, done_ff, done_ff, "finished state cleared")
   `GPL_ASSERT(a_match_fields, clock, reset, !(rsp_valid && rsp_finish_cause == gpl_pkg::CAUSE_MATCH) || (rsp_finished && !rsp_locked), "match result not finished and unlocked")
   `GPL_ASSERT(a_cell_range, clock, reset, !(rsp_valid && rsp_cell_recorded) || (rsp_cell_index < gpl_pkg::CELL_W'(gpl_pkg::GRID_CELLS)), "recorded cell outside the grid")
   `GPL_ASSERT(a_ring_write_armed, clock, reset, !ring_ctrl.write || armed_ff, "ring written while disarmed")

endmodule

`default_nettype wire
